[design/csls_pkg.sv]
// Package for the copy state likelihood select unit: constants, types and functions.
`default_nettype none
package csls_pkg;
   localparam int MaxCandidates = 16;
   localparam int SlotBits = $clog2(MaxCandidates);
   localparam int LogTableBits = 10;
   localparam int RomSize = 1 << LogTableBits;
   localparam int SumBits = 48;
   localparam logic signed [SumBits-1:0] SumMax = {1'b0, {(SumBits-1){1'b1}}};
   localparam logic signed [SumBits-1:0] SumMin = {1'b1, {(SumBits-1){1'b0}}};
   localparam logic signed [SumBits-1:0] T5Log2Norm = 48'sd91582;
   localparam logic [29:0] Ln2Q30 = 30'd744261118;

   localparam logic [1:0] OpLoad = 2'd0;
   localparam logic [1:0] OpPoint = 2'd1;
   localparam logic [1:0] OpFinish = 2'd2;

   localparam logic [1:0] CsrCount = 2'd0;
   localparam logic [1:0] CsrRatioInv = 2'd1;
   localparam logic [1:0] CsrBafInv = 2'd2;

   // One candidate entry as a cell holds it.
   typedef struct packed {
      logic [3:0]         total;
      logic [3:0]         minor;
      logic [23:0]        ratio;
      logic [23:0]        baf;
      logic signed [31:0] ratio_off;
      logic signed [31:0] baf_off;
   } cand_type;

   // Mantissa table entry: floor(2^20 * log2(1 + i / RomSize)) by repeated squaring.
   function automatic logic [19:0] log_mant(input logic [LogTableBits-1:0] i);
      logic [63:0] m;
      logic [19:0] v;
      m = (64'd1 << 30) + (64'(i) << (30 - LogTableBits));
      v = '0;
      for (int b = 19; b >= 0; b--) begin
         m = (m * m) >> 30;
         if (m >= (64'd2 << 30)) begin
            v[b] = 1'b1;
            m = m >> 1;
         end
      end
      return v;
   endfunction

   // Saturating add into a 48-bit sum.
   function automatic logic signed [SumBits-1:0] sat_add(input logic signed [SumBits-1:0] a,
                                                        input logic signed [SumBits:0] b);
      logic signed [SumBits+1:0] r;
      r = {{2{a[SumBits-1]}}, a} + {b[SumBits], b};
      if (r > $signed({2'b00, SumMax})) return SumMax;
      if (r < $signed({2'b11, SumMin})) return SumMin;
      return r[SumBits-1:0];
   endfunction
endpackage
`default_nettype wire

[design/csls_term.sv]
// Multi-cycle Student-t log2 term unit: deviation, square, restoring division, lookup.
`default_nettype none
module csls_term (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [23:0]  obs,
   input  wire logic [23:0]  expv,
   input  wire logic [23:0]  inv,
   input  wire logic signed [31:0] offset,
   output logic              done,
   output logic signed [csls_pkg::SumBits:0] term
);
   typedef enum logic [2:0] {S_IDLE, S_MUL, S_SQ, S_NORM, S_DIV, S_LUT, S_OUT} state_type;
   state_type state_ff;
   logic [23:0] d_ff;
   logic [27:0] x_ff;
   logic [79:0] den_ff;
   logic [80:0] rem_ff;
   logic [5:0]  k_ff;
   logic [3:0]  cnt_ff;
   logic [csls_pkg::LogTableBits-1:0] idx_ff;
   logic signed [31:0] off_ff;
   logic signed [csls_pkg::SumBits:0] term_ff;
   logic done_ff;
   logic [19:0] mant_ff;
   logic [19:0] mant_rom [csls_pkg::RomSize];
   logic [80:0] num_sh;
   logic [80:0] rem2;
   logic signed [csls_pkg::SumBits:0] l_val;

   // Mantissa table contents, log2(1 + i / RomSize) in Q0.20.
   initial begin
      for (int i = 0; i < csls_pkg::RomSize; i++) begin
         mant_rom[i] = csls_pkg::log_mant(csls_pkg::LogTableBits'(i));
      end
   end

   // Registered table read.
   always_ff @(posedge clock) begin
      mant_ff <= mant_rom[idx_ff];
   end

   assign num_sh = 81'(81'd5 << (32 + k_ff));
   assign rem2 = rem_ff << 1;
   assign l_val = -$signed({43'd0, k_ff}) * 49'sd65536 + $signed({33'd0, mant_ff[19:4]});
   assign done = done_ff;
   assign term = term_ff;

   // Sequencer: x = d*inv>>20, den = 5<<32 + x^2, find k, divide for the index.
   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: if (start) begin
               d_ff <= (obs >= expv) ? obs - expv : expv - obs;
               off_ff <= offset;
               state_ff <= S_MUL;
            end
            S_MUL: begin
               x_ff <= 28'((48'(d_ff) * 48'(inv)) >> 20);
               state_ff <= S_SQ;
            end
            S_SQ: begin
               den_ff <= (80'd5 << 32) + 80'(56'(x_ff) * 56'(x_ff));
               k_ff <= '0;
               state_ff <= S_NORM;
            end
            S_NORM: begin
               if (num_sh < 81'(den_ff) && k_ff < 6'd40) begin
                  k_ff <= k_ff + 6'd1;
               end else begin
                  rem_ff <= num_sh - 81'(den_ff);
                  idx_ff <= '0;
                  cnt_ff <= '0;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (rem2 >= 81'(den_ff)) begin
                  rem_ff <= rem2 - 81'(den_ff);
                  idx_ff <= {idx_ff[csls_pkg::LogTableBits-2:0], 1'b1};
               end else begin
                  rem_ff <= rem2;
                  idx_ff <= {idx_ff[csls_pkg::LogTableBits-2:0], 1'b0};
               end
               cnt_ff <= cnt_ff + 4'd1;
               if (cnt_ff == 4'(csls_pkg::LogTableBits - 1)) state_ff <= S_LUT;
            end
            S_LUT: begin
               // The table read of the final index lands in mant_ff.
               state_ff <= S_OUT;
            end
            S_OUT: begin
               term_ff <= 49'sd3 * l_val - 49'(csls_pkg::T5Log2Norm) - 49'(off_ff);
               done_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

[design/csls_cell.sv]
// One chain cell: holds a candidate entry and its score sum, shifts to its neighbor.
`default_nettype none
module csls_cell (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire csls_pkg::cand_type  load_cand,
   input  wire logic                shift,
   input  wire logic                clear,
   input  wire csls_pkg::cand_type  prev_cand,
   input  wire logic signed [csls_pkg::SumBits-1:0] prev_sum,
   output csls_pkg::cand_type       cand,
   output logic signed [csls_pkg::SumBits-1:0] sum
);
   csls_pkg::cand_type cand_ff;
   logic signed [csls_pkg::SumBits-1:0] sum_ff;
   assign cand = cand_ff;
   assign sum = sum_ff;

   // Entry is written by a load, rotated by the chain, sums cleared on finish.
   always_ff @(posedge clock) begin
      if (load) cand_ff <= load_cand;
      else if (shift) cand_ff <= prev_cand;
      if (reset || clear) sum_ff <= '0;
      else if (shift) sum_ff <= prev_sum;
   end
endmodule
`default_nettype wire

[design/copy_state_likelihood_select_unit.sv]
// Top level of the copy state likelihood select unit.
`default_nettype none
// Candidates sit in a ring of 16 cells that rotates by one place per step; the
// head cell feeds a shared term unit and its updated sum re-enters at the tail.
// A point runs the term unit on each term of each active candidate, whose run
// time grows with k (at most 22), the normalization count of the term unit;
// het points run a second term for each candidate with nonzero total copies. The
// ring then turns the rest of the way home. A finish rotates the ring once through
// the ln2 product pipeline; then the output state pulses rsp_valid for one cycle
// as busy falls; the receiver cannot stall. busy is high while an item is at work.
module copy_state_likelihood_select_unit (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire logic [1:0]   req_opcode,
   input  wire logic [3:0]   req_cand_slot,
   input  wire logic [3:0]   req_cand_total_copies,
   input  wire logic [3:0]   req_cand_minor_copies,
   input  wire logic [23:0]  req_cand_expected_ratio,
   input  wire logic [23:0]  req_cand_expected_baf,
   input  wire logic signed [31:0] req_cand_ratio_offset,
   input  wire logic signed [31:0] req_cand_baf_offset,
   input  wire logic [23:0]  req_point_ratio,
   input  wire logic [23:0]  req_point_baf,
   input  wire logic         req_point_het,
   input  wire logic         csr_write,
   input  wire logic [1:0]   csr_index,
   input  wire logic [23:0]  csr_data,
   output logic              rsp_valid,
   output logic [3:0]        rsp_best_total_copies,
   output logic signed [4:0] rsp_best_major_copies,
   output logic [3:0]        rsp_best_minor_copies,
   output logic signed [47:0] rsp_best_score
);
   localparam int N = csls_pkg::MaxCandidates;
   localparam int SB = csls_pkg::SumBits;
   typedef enum logic [2:0] {S_IDLE, S_RT, S_RW, S_BT, S_BW, S_FM, S_FC, S_FO} state_type;
   state_type state_ff;

   logic [4:0] count_ff;
   logic [23:0] rinv_ff, binv_ff;
   logic [23:0] pr_ff, pb_ff;
   logic het_ff;
   logic [csls_pkg::SlotBits:0] step_ff;
   logic [csls_pkg::SlotBits:0] active;
   logic signed [SB-1:0] acc_ff;
   logic signed [SB-1:0] best_ff;
   logic [3:0] bt_ff, bm_ff;
   logic [SB-1:0] mag_ff;
   logic sneg_ff;
   logic sneg_d_ff;
   logic [SB+29:0] prod_ff;
   logic [53:0] prod_hi, prod_lo;
   logic [3:0] ct_ff, cm_ff;
   logic [3:0] ct_d_ff, cm_d_ff;
   logic valid_ff;

   csls_pkg::cand_type cands [N];
   logic signed [SB-1:0] sums [N];
   logic shift, clear, load_any;
   logic [N-1:0] load_sel;
   csls_pkg::cand_type load_cand;
   csls_pkg::cand_type head;
   logic signed [SB-1:0] tail_sum;

   logic t_start, t_done;
   logic [23:0] t_obs, t_exp, t_inv;
   logic signed [31:0] t_off;
   logic signed [SB:0] t_term;
   logic signed [SB-1:0] scaled;

   assign active = (count_ff > 5'(N)) ? (csls_pkg::SlotBits+1)'(N)
                                      : (csls_pkg::SlotBits+1)'(count_ff);
   assign head = cands[0];
   assign busy = (state_ff != S_IDLE);
   assign load_any = start && !busy && req_opcode == csls_pkg::OpLoad;
   assign load_cand = '{total: req_cand_total_copies, minor: req_cand_minor_copies,
                        ratio: req_cand_expected_ratio, baf: req_cand_expected_baf,
                        ratio_off: req_cand_ratio_offset, baf_off: req_cand_baf_offset};

   // Row of cells rotating toward slot 0; the tail takes the head's new sum.
   for (genvar g = 0; g < N; g++) begin : g_cell
      csls_pkg::cand_type pc;
      logic signed [SB-1:0] ps;
      assign load_sel[g] = load_any && req_cand_slot == 4'(g);
      assign pc = cands[(g + 1) % N];
      assign ps = (g == N - 1) ? tail_sum : sums[(g + 1) % N];
      csls_cell u_cell (
         .clock(clock), .reset(reset), .load(load_sel[g]), .load_cand(load_cand),
         .shift(shift), .clear(clear), .prev_cand(pc), .prev_sum(ps),
         .cand(cands[g]), .sum(sums[g]));
   end

   // The spread is read by the term unit in the cycle after its start.
   assign t_obs = (state_ff == S_BT) ? pb_ff : pr_ff;
   assign t_exp = (state_ff == S_BT) ? head.baf : head.ratio;
   assign t_inv = (state_ff == S_BT || state_ff == S_BW) ? binv_ff : rinv_ff;
   assign t_off = (state_ff == S_BT) ? head.baf_off : head.ratio_off;
   assign t_start = (state_ff == S_RT) || (state_ff == S_BT);

   csls_term u_term (
      .clock(clock), .reset(reset), .start(t_start), .obs(t_obs), .expv(t_exp),
      .inv(t_inv), .offset(t_off), .done(t_done), .term(t_term));

   // Rotation control and the sum that leaves the head each step.
   always_comb begin
      shift = 1'b0;
      tail_sum = sums[0];
      clear = 1'b0;
      case (state_ff)
         S_RW: if (t_done) begin
            if (!(het_ff && head.total != 4'd0)) begin
               shift = 1'b1;
               tail_sum = csls_pkg::sat_add(acc_ff, t_term);
            end
         end
         S_BW: if (t_done) begin
            shift = 1'b1;
            tail_sum = csls_pkg::sat_add(acc_ff, t_term);
         end
         S_FM: shift = (step_ff < (csls_pkg::SlotBits+1)'(N));
         S_FC: shift = (step_ff != (csls_pkg::SlotBits+1)'(N));
         S_FO: clear = 1'b1;
         default: ;
      endcase
   end

   // ln2 product split into two halves of the magnitude.
   assign prod_hi = 54'(mag_ff[SB-1:24]) * 54'(csls_pkg::Ln2Q30);
   assign prod_lo = 54'(mag_ff[23:0]) * 54'(csls_pkg::Ln2Q30);

   // ln2 scaling of the product register.
   assign scaled = sneg_ff ? -$signed(prod_ff[SB+29:30]) : $signed(prod_ff[SB+29:30]);

   // Control: points rotate the whole ring, inactive cells pass through unchanged.
   always_ff @(posedge clock) begin
      valid_ff <= 1'b0;
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rinv_ff <= 24'd65536;
         binv_ff <= 24'd65536;
      end else begin
         if (csr_write) begin
            case (csr_index)
               csls_pkg::CsrCount: count_ff <= csr_data[4:0];
               csls_pkg::CsrRatioInv: rinv_ff <= csr_data;
               csls_pkg::CsrBafInv: binv_ff <= csr_data;
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: if (start) begin
               pr_ff <= req_point_ratio;
               pb_ff <= req_point_baf;
               het_ff <= req_point_het;
               step_ff <= '0;
               best_ff <= csls_pkg::SumMin;
               bt_ff <= '0;
               bm_ff <= '0;
               if (req_opcode == csls_pkg::OpPoint && active != '0) state_ff <= S_RT;
               else if (req_opcode == csls_pkg::OpFinish) state_ff <= S_FM;
            end
            S_RT: begin
               acc_ff <= sums[0];
               state_ff <= S_RW;
            end
            S_RW: if (t_done) begin
               if (het_ff && head.total != 4'd0) begin
                  acc_ff <= csls_pkg::sat_add(acc_ff, t_term);
                  state_ff <= S_BT;
               end else begin
                  step_ff <= step_ff + 1'b1;
                  state_ff <= (step_ff + 1'b1 == active) ? S_FC : S_RT;
               end
            end
            S_BT: state_ff <= S_BW;
            S_BW: if (t_done) begin
               step_ff <= step_ff + 1'b1;
               state_ff <= (step_ff + 1'b1 == active) ? S_FC : S_RT;
            end
            S_FC: begin
               // Finish the rotation so slot 0 is at the head again.
               if (step_ff == (csls_pkg::SlotBits+1)'(N)) state_ff <= S_IDLE;
               else step_ff <= step_ff + 1'b1;
            end
            S_FM: begin
               // Scale one sum per cycle via mag_ff and prod_ff; compare each product from prod_ff.
               if (step_ff != '0 && step_ff <= active + 1'b1 && step_ff >= 2) begin
                  if (scaled > best_ff) begin
                     best_ff <= scaled;
                     bt_ff <= ct_ff;
                     bm_ff <= cm_ff;
                  end
               end
               prod_ff <= (78'(prod_hi) << 24) + 78'(prod_lo);
               ct_ff <= ct_d_ff;
               cm_ff <= cm_d_ff;
               mag_ff <= sums[0][SB-1] ? SB'(-sums[0]) : sums[0];
               sneg_d_ff <= sums[0][SB-1];
               sneg_ff <= sneg_d_ff;
               ct_d_ff <= head.total;
               cm_d_ff <= head.minor;
               step_ff <= step_ff + 1'b1;
               if (step_ff == (csls_pkg::SlotBits+1)'(N + 1)) state_ff <= S_FO;
            end
            S_FO: begin
               valid_ff <= 1'b1;
               rsp_best_total_copies <= bt_ff;
               rsp_best_minor_copies <= bm_ff;
               rsp_best_major_copies <= $signed({1'b0, bt_ff}) - $signed({1'b0, bm_ff});
               rsp_best_score <= best_ff;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = valid_ff;
endmodule
`default_nettype wire
